/* rtl/acre_pkg.sv */
// ----------------------------------------------------------------------------
// acre_pkg
// Shared constants and types for the alignment run encoder.
// ----------------------------------------------------------------------------
package acre_pkg;

    localparam int LEN_BITS_DEF    = 16;
    localparam int QUEUE_DEPTH_DEF = 4;

    localparam logic [7:0]  GAP_CHAR   = 8'd45;
    localparam logic [15:0] EDIT_MAX   = 16'hFFFF;
    localparam logic [15:0] SKIP_RESET = 16'd100;

    localparam logic [2:0] KIND_MATCH    = 3'd0;
    localparam logic [2:0] KIND_MISMATCH = 3'd1;
    localparam logic [2:0] KIND_INSERT   = 3'd2;
    localparam logic [2:0] KIND_DELETE   = 3'd3;
    localparam logic [2:0] KIND_SKIP     = 3'd4;
    localparam logic [2:0] KIND_CLIP     = 3'd5;

    localparam logic ADDR_SKIP_THRESHOLD = 1'b0;

    // up to three operations caused by one column
    // slot 0: front clip or ended run, slot 1: final run, slot 2: back clip
    typedef struct packed {
        logic [2:0]  slot_valid;
        logic [2:0]  kind0;
        logic [15:0] len0;
        logic [2:0]  kind1;
        logic [15:0] len1;
        logic [15:0] clip_len;
        logic [15:0] edits;
    } op_pkt_t;

    typedef struct packed {
        logic push;
        logic pop;
    } queue_ctrl_t;

endpackage

/* rtl/acre_if.sv */
// ----------------------------------------------------------------------------
// acre_col_if / acre_op_if
// Valid/ready channels for alignment columns and encoded operations.
// ----------------------------------------------------------------------------
interface acre_col_if;
    logic        valid;
    logic        ready;
    logic [7:0]  ref_char;
    logic [7:0]  query_char;
    logic        first_column;
    logic        last_column;
    logic [15:0] query_start;
    logic [15:0] query_end;
    logic [15:0] read_length;

    modport source (
        output valid, ref_char, query_char, first_column, last_column,
               query_start, query_end, read_length,
        input  ready
    );
    modport sink (
        input  valid, ref_char, query_char, first_column, last_column,
               query_start, query_end, read_length,
        output ready
    );
endinterface

interface acre_op_if;
    logic        valid;
    logic        ready;
    logic [2:0]  op_kind;
    logic [15:0] op_length;
    logic        last_op;
    logic [15:0] edit_count;

    modport source (
        output valid, op_kind, op_length, last_op, edit_count,
        input  ready
    );
    modport sink (
        input  valid, op_kind, op_length, last_op, edit_count,
        output ready
    );
endinterface

/* rtl/alignment_cigar_run_encoder_core.sv */
// ----------------------------------------------------------------------------
// alignment_cigar_run_encoder_core
// Run-length encodes alignment columns into match, mismatch, insertion,
// deletion, skipped and soft clip operations with a saturating edit count.
//
// col: one alignment column per transaction; query_start, query_end and
//   read_length are sampled on the first column of an alignment.
// op: one operation per transaction; last_op marks the end of an alignment
//   and carries the edit count.
// apb: skip_threshold at byte address 0, reset value 100.
// A column is taken in every cycle while the packet queue has room; a column
//   causing k operations is sent as k separate operations (k up to 3), and
//   the first operation of a column passes through the packet queue and then the output register.
// The queue holds QUEUE_DEPTH packets, so a stalled receiver stops col only
//   once the queue fills; nothing is dropped.
// Reset clears the open run, the queue and the output valid flag.
// ----------------------------------------------------------------------------
module alignment_cigar_run_encoder_core #(
    parameter int LEN_BITS    = acre_pkg::LEN_BITS_DEF,
    parameter int QUEUE_DEPTH = acre_pkg::QUEUE_DEPTH_DEF
) (
    input  logic        clk,
    input  logic        rst_n,
    acre_col_if.sink    col,
    acre_op_if.source   op,
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import acre_pkg::*;

    logic [15:0]  skip_reg, skip_next;
    logic         cfg_write;
    op_pkt_t      front_pkt;
    op_pkt_t      head_pkt;
    queue_ctrl_t  qctrl;
    logic         q_push;
    logic         q_pop;
    logic         q_full;
    logic         q_empty;

    assign pready    = 1'b1;
    assign cfg_write = psel && penable && pwrite && (paddr[2] == ADDR_SKIP_THRESHOLD);
    assign skip_next = cfg_write ? pwdata[15:0] : skip_reg;
    assign prdata    = (paddr[2] == ADDR_SKIP_THRESHOLD) ? {16'd0, skip_reg} : 32'd0;
    assign qctrl     = '{push: q_push, pop: q_pop};

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            skip_reg <= SKIP_RESET;
        else
            skip_reg <= skip_next;
    end

    acre_front #(
        .LEN_BITS (LEN_BITS)
    ) u_front (
        .clk            (clk),
        .rst_n          (rst_n),
        .col            (col),
        .skip_threshold (skip_reg),
        .queue_full     (q_full),
        .push           (q_push),
        .pkt            (front_pkt)
    );

    acre_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk    (clk),
        .rst_n  (rst_n),
        .ctrl   (qctrl),
        .wr_pkt (front_pkt),
        .head   (head_pkt),
        .full   (q_full),
        .empty  (q_empty)
    );

    acre_back u_back (
        .clk         (clk),
        .rst_n       (rst_n),
        .head        (head_pkt),
        .queue_empty (q_empty),
        .pop         (q_pop),
        .op          (op)
    );

endmodule

/* rtl/acre_front.sv */
// ----------------------------------------------------------------------------
// acre_front
// Accepts columns, tracks the open run and builds the operation packet.
// ----------------------------------------------------------------------------
module acre_front #(
    parameter int LEN_BITS = acre_pkg::LEN_BITS_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    acre_col_if.sink              col,
    input  logic [15:0]           skip_threshold,
    input  logic                  queue_full,
    output logic                  push,
    output acre_pkg::op_pkt_t     pkt
);
    import acre_pkg::*;

    localparam int SUM_W = ((LEN_BITS > 16) ? LEN_BITS : 16) + 1;
    localparam int CMP_W = (LEN_BITS > 16) ? LEN_BITS : 16;

    localparam logic [1:0] RUN_MATCH    = KIND_MATCH[1:0];
    localparam logic [1:0] RUN_MISMATCH = KIND_MISMATCH[1:0];
    localparam logic [1:0] RUN_INSERT   = KIND_INSERT[1:0];
    localparam logic [1:0] RUN_DELETE   = KIND_DELETE[1:0];

    logic [1:0]          run_kind_reg,  run_kind_next;
    logic [LEN_BITS-1:0] run_len_reg,   run_len_next;
    logic [15:0]         edit_reg,      edit_next;
    logic [15:0]         back_reg,      back_next;
    logic                run_open_reg,  run_open_next;

    logic                accept;
    logic                cur_open;
    logic [15:0]         cur_edit;
    logic [15:0]         cur_back;
    logic [15:0]         back_calc;
    logic                cont;
    logic [1:0]          new_kind;
    logic [1:0]          kind_a;
    logic [LEN_BITS-1:0] len_inc;
    logic [LEN_BITS-1:0] len_a;
    logic [15:0]         edit_close;
    logic [15:0]         edit_a;
    logic [15:0]         edit_b;

    function automatic logic [1:0] open_kind(input logic [7:0] rc, input logic [7:0] qc);
        logic [1:0] k;
        if (rc == GAP_CHAR)
            k = RUN_INSERT;
        else if (qc == GAP_CHAR)
            k = RUN_DELETE;
        else if (rc == qc)
            k = RUN_MATCH;
        else
            k = RUN_MISMATCH;
        return k;
    endfunction

    function automatic logic continues(input logic [1:0] k, input logic [7:0] rc,
                                       input logic [7:0] qc);
        logic c;
        case (k)
            RUN_INSERT: c = (rc == GAP_CHAR);
            RUN_DELETE: c = (qc == GAP_CHAR);
            RUN_MATCH:  c = (rc == qc);
            default:    c = (rc != GAP_CHAR) && (qc != GAP_CHAR) && (rc != qc);
        endcase
        return c;
    endfunction

    function automatic logic [15:0] sat_add(input logic [15:0] e, input logic [LEN_BITS-1:0] l);
        logic [SUM_W-1:0] s;
        s = SUM_W'(e) + SUM_W'(l);
        return (s > SUM_W'(EDIT_MAX)) ? EDIT_MAX : s[15:0];
    endfunction

    function automatic logic [2:0] emit_kind(input logic [1:0] k, input logic [LEN_BITS-1:0] l,
                                             input logic [15:0] thr);
        logic [2:0] r;
        if (k == RUN_DELETE && CMP_W'(l) >= CMP_W'(thr))
            r = KIND_SKIP;
        else
            r = {1'b0, k};
        return r;
    endfunction

    assign col.ready = !queue_full;
    assign accept    = col.valid && !queue_full;

    always_comb
    begin
        cur_open   = col.first_column ? 1'b0 : run_open_reg;
        cur_edit   = col.first_column ? 16'd0 : edit_reg;
        back_calc  = (col.read_length > col.query_end) ? (col.read_length - col.query_end) : 16'd0;
        cur_back   = col.first_column ? back_calc : back_reg;
        cont       = cur_open && continues(run_kind_reg, col.ref_char, col.query_char);
        new_kind   = open_kind(col.ref_char, col.query_char);
        len_inc    = (run_len_reg == '1) ? run_len_reg : run_len_reg + LEN_BITS'(1);
        kind_a     = cont ? run_kind_reg : new_kind;
        len_a      = cont ? len_inc : LEN_BITS'(1);
        edit_close = sat_add(cur_edit, (run_kind_reg == RUN_MATCH) ? '0 : run_len_reg);
        edit_a     = (cur_open && !cont) ? edit_close : cur_edit;
        edit_b     = sat_add(edit_a, (kind_a == RUN_MATCH) ? '0 : len_a);

        pkt.slot_valid[0] = (col.first_column && col.query_start > 16'd1) || (cur_open && !cont);
        pkt.slot_valid[1] = col.last_column;
        pkt.slot_valid[2] = col.last_column && (cur_back != 16'd0);
        pkt.kind0    = col.first_column ? KIND_CLIP
                                        : emit_kind(run_kind_reg, run_len_reg, skip_threshold);
        pkt.len0     = col.first_column ? (col.query_start - 16'd1) : 16'(run_len_reg);
        pkt.kind1    = emit_kind(kind_a, len_a, skip_threshold);
        pkt.len1     = 16'(len_a);
        pkt.clip_len = cur_back;
        pkt.edits    = edit_b;

        push = accept && (pkt.slot_valid != 3'b000);

        run_kind_next = run_kind_reg;
        run_len_next  = run_len_reg;
        edit_next     = edit_reg;
        back_next     = back_reg;
        run_open_next = run_open_reg;
        if (accept)
        begin
            if (col.last_column)
            begin
                run_kind_next = RUN_MATCH;
                run_len_next  = '0;
                edit_next     = 16'd0;
                back_next     = 16'd0;
                run_open_next = 1'b0;
            end
            else
            begin
                run_kind_next = kind_a;
                run_len_next  = len_a;
                edit_next     = edit_a;
                back_next     = cur_back;
                run_open_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            run_kind_reg <= RUN_MATCH;
            run_len_reg  <= '0;
            edit_reg     <= 16'd0;
            back_reg     <= 16'd0;
            run_open_reg <= 1'b0;
        end
        else
        begin
            run_kind_reg <= run_kind_next;
            run_len_reg  <= run_len_next;
            edit_reg     <= edit_next;
            back_reg     <= back_next;
            run_open_reg <= run_open_next;
        end
    end

endmodule

/* rtl/acre_queue.sv */
// ----------------------------------------------------------------------------
// acre_queue
// Short packet queue between the column front end and the operation back end.
// ----------------------------------------------------------------------------
module acre_queue #(
    parameter int DEPTH = acre_pkg::QUEUE_DEPTH_DEF
) (
    input  logic                  clk,
    input  logic                  rst_n,
    input  acre_pkg::queue_ctrl_t ctrl,
    input  acre_pkg::op_pkt_t     wr_pkt,
    output acre_pkg::op_pkt_t     head,
    output logic                  full,
    output logic                  empty
);
    import acre_pkg::*;

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    op_pkt_t            mem_reg [DEPTH];
    logic [PTR_W-1:0]   wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]   rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]   count_reg,  count_next;
    logic               do_push;
    logic               do_pop;

    assign full    = (count_reg == CNT_W'(DEPTH));
    assign empty   = (count_reg == '0);
    assign do_push = ctrl.push && !full;
    assign do_pop  = ctrl.pop && !empty;
    assign head    = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        if (do_push && !do_pop)
            count_next = count_reg + CNT_W'(1);
        else if (do_pop && !do_push)
            count_next = count_reg - CNT_W'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            mem_reg[wr_ptr_reg] <= wr_pkt;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

endmodule

/* rtl/acre_back.sv */
// ----------------------------------------------------------------------------
// acre_back
// Unpacks queued packets into single operations behind an output register.
// ----------------------------------------------------------------------------
module acre_back (
    input  logic              clk,
    input  logic              rst_n,
    input  acre_pkg::op_pkt_t head,
    input  logic              queue_empty,
    output logic              pop,
    acre_op_if.source         op
);
    import acre_pkg::*;

    logic        out_valid_reg, out_valid_next;
    logic [2:0]  kind_reg,      kind_next;
    logic [15:0] len_reg,       len_next;
    logic        last_reg,      last_next;
    logic [15:0] edit_reg,      edit_next;
    logic [2:0]  done_reg,      done_next;

    logic [2:0]  remaining;
    logic [2:0]  sel;
    logic [2:0]  after;
    logic        take;
    logic        sel_last;

    assign op.valid      = out_valid_reg;
    assign op.op_kind    = kind_reg;
    assign op.op_length  = len_reg;
    assign op.last_op    = last_reg;
    assign op.edit_count = edit_reg;

    always_comb
    begin
        remaining = head.slot_valid & ~done_reg;
        if (remaining[0])
            sel = 3'b001;
        else if (remaining[1])
            sel = 3'b010;
        else
            sel = 3'b100;
        after = remaining & ~sel;
        take  = !queue_empty && (!out_valid_reg || op.ready);
        pop   = take && (after == 3'b000);

        sel_last = sel[2] || (sel[1] && !head.slot_valid[2]);

        kind_next      = kind_reg;
        len_next       = len_reg;
        last_next      = last_reg;
        edit_next      = edit_reg;
        done_next      = done_reg;
        out_valid_next = out_valid_reg;
        if (take)
        begin
            out_valid_next = 1'b1;
            last_next      = sel_last;
            edit_next      = sel_last ? head.edits : 16'd0;
            case (sel)
                3'b001:
                begin
                    kind_next = head.kind0;
                    len_next  = head.len0;
                end
                3'b010:
                begin
                    kind_next = head.kind1;
                    len_next  = head.len1;
                end
                default:
                begin
                    kind_next = KIND_CLIP;
                    len_next  = head.clip_len;
                end
            endcase
            done_next = (after == 3'b000) ? 3'b000 : (done_reg | sel);
        end
        else if (op.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        kind_reg <= kind_next;
        len_reg  <= len_next;
        last_reg <= last_next;
        edit_reg <= edit_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
            done_reg      <= 3'b000;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
            done_reg      <= done_next;
        end
    end

endmodule

/* rtl/acre_checker.sv */
// ----------------------------------------------------------------------------
// acre_checker
// Port-level checks on the operation channel, bound to the core.
// ----------------------------------------------------------------------------
module acre_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        op_valid,
    input logic        op_ready,
    input logic [2:0]  op_kind,
    input logic [15:0] op_length,
    input logic        last_op,
    input logic [15:0] edit_count
);
    import acre_pkg::*;

    a_hold_valid: assert property (@(posedge clk) disable iff (!rst_n)
        op_valid && !op_ready |=> op_valid)
        else $error("operation dropped while stalled");

    a_hold_payload: assert property (@(posedge clk) disable iff (!rst_n)
        op_valid && !op_ready |=> $stable(op_kind) && $stable(op_length)
                                  && $stable(last_op) && $stable(edit_count))
        else $error("operation changed while stalled");

    a_kind_range: assert property (@(posedge clk) disable iff (!rst_n)
        op_valid |-> op_kind <= KIND_CLIP)
        else $error("operation kind out of range");

    a_edit_on_last: assert property (@(posedge clk) disable iff (!rst_n)
        op_valid && !last_op |-> edit_count == 16'd0)
        else $error("edit count on a non-final operation");

endmodule

bind alignment_cigar_run_encoder_core acre_checker u_acre_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .op_valid   (op.valid),
    .op_ready   (op.ready),
    .op_kind    (op.op_kind),
    .op_length  (op.op_length),
    .last_op    (op.last_op),
    .edit_count (op.edit_count)
);
